// ----- sv/bfql_pkg.sv -----
// Package for the bitmap font quad layout block: payload structs and codes.
// Used by bitmap_font_quad_layout_top and its checker; depends on nothing.
package bfql_pkg;

  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  localparam logic [CfgIdxW-1:0] CfgSpaceAdvance = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFontHeight   = 2'd1;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdChar = 1'b1;

  localparam logic KindVertex = 1'b0;
  localparam logic KindLength = 1'b1;

  localparam logic [7:0] FirstCode = 8'd32;

  localparam logic [7:0] SpaceAdvanceReset = 8'd3;
  localparam logic [7:0] FontHeightReset   = 8'd16;

  // Result index within one character: six corners, then the length report.
  localparam logic [2:0] VtxTopLeftA  = 3'd0;
  localparam logic [2:0] VtxBotRightA = 3'd1;
  localparam logic [2:0] VtxBotLeft   = 3'd2;
  localparam logic [2:0] VtxTopLeftB  = 3'd3;
  localparam logic [2:0] VtxTopRight  = 3'd4;
  localparam logic [2:0] VtxBotRightB = 3'd5;
  localparam logic [2:0] ResLength    = 3'd6;

  typedef struct packed {
    logic               command;
    logic [6:0]         glyph_slot;
    logic [15:0]        tex_left;
    logic [15:0]        tex_right;
    logic [7:0]         glyph_width;
    logic [7:0]         char_code;
    logic               first_char;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic               last_char;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        tex_u;
    logic               tex_v;
    logic [15:0]        line_length;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [7:0]  width;
  } glyph_t;

endpackage

// ----- sv/bitmap_font_quad_layout_top.sv -----
// Bitmap font quad layout: glyph table, pen tracking and vertex sequencer.
// Depends on bfql_pkg for the payload structs and codes.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------
//  in      | input     | in_valid/in_stall | bfql_pkg::in_t  (load or char)
//  out     | output    | out_valid/stall   | bfql_pkg::out_t (vertex/length)
//  cfg     | input     | cfg_valid/ready   | cfg_index, cfg_data (8 bit)
//
// A load gives no result. A printable character gives six vertex transfers,
// one per cycle while the output does not stall, plus a length report when it
// ends a line; spaces, ignored codes and loads give no vertices. The pen stage
// can hold the next character while the sequencer is still busy with the last.
// The glyph table read and the pen stage take a character in together; its first
// result comes from the sequencer register. Reset clears pen, length and all valid
// flags; the glyph table has no reset. Stalls back up through sequencer and pen stage.
module bitmap_font_quad_layout_top #(
  parameter int unsigned GLYPH_COUNT = 95
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  bfql_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output bfql_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bfql_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [bfql_pkg::CfgDataW-1:0]       cfg_data_i
);
  import bfql_pkg::*;

  localparam int unsigned IdxW = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam logic [8:0]  GlyphCountW = 9'(GLYPH_COUNT);

  function automatic logic signed [15:0] sat_s16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers; the port never stalls.
  // ---------------------------------------------------------------------
  logic [7:0] space_adv_q, font_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_adv_q   <= SpaceAdvanceReset;
      font_height_q <= FontHeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSpaceAdvance: space_adv_q   <= cfg_data_i;
        CfgFontHeight:   font_height_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Input decode and glyph table
  // ---------------------------------------------------------------------
  logic       in_xfer;
  logic       in_is_char, in_is_load_ok;
  logic [7:0] in_code_off;
  logic       in_is_glyph, in_is_space;
  logic [7:0] load_slot8;

  assign in_xfer       = in_valid_i && !in_stall_o;
  assign in_is_char    = (in_data_i.command == CmdChar);
  assign load_slot8    = {1'b0, in_data_i.glyph_slot};
  assign in_is_load_ok = !in_is_char && ({1'b0, load_slot8} < GlyphCountW);
  assign in_code_off   = in_data_i.char_code - FirstCode;
  assign in_is_space   = (in_data_i.char_code == FirstCode);
  assign in_is_glyph   = (in_data_i.char_code > FirstCode) &&
                         ({1'b0, in_code_off} < GlyphCountW);

  glyph_t glyph_mem [GLYPH_COUNT];
  glyph_t glyph_rd_q;

  // Write on the load transfer, read on the char transfer: a char right after
  // a load to the same slot sees the new entry.
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_is_load_ok) begin
      glyph_mem[load_slot8[IdxW-1:0]] <= '{left:  in_data_i.tex_left,
                                           right: in_data_i.tex_right,
                                           width: in_data_i.glyph_width};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_is_char && in_is_glyph) begin
      glyph_rd_q <= glyph_mem[in_code_off[IdxW-1:0]];
    end
  end

  // ---------------------------------------------------------------------
  // Pen stage: holds one char item, updates pen and length when it leaves.
  // ---------------------------------------------------------------------
  logic        b_valid_q, b_glyph_q, b_space_q;
  in_t         b_item_q;
  logic        b_go;

  logic               c_valid_q;
  logic               c_done;

  logic signed [15:0] pen_x_q, pen_y_q;
  logic [15:0]        len_q;

  logic signed [15:0] px0, py0;
  logic [15:0]        len0;
  logic [8:0]         adv;
  logic signed [15:0] pen_x_d;
  logic [16:0]        len_sum;
  logic [15:0]        len_d;
  logic signed [15:0] xr, yb;
  logic               b_to_c;

  assign b_go       = !c_valid_q || c_done;
  assign in_stall_o = b_valid_q && !b_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (in_xfer && in_is_char) begin
      b_valid_q <= 1'b1;
    end else if (b_go) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && in_is_char) begin
      b_item_q  <= in_data_i;
      b_glyph_q <= in_is_glyph;
      b_space_q <= in_is_space;
    end
  end

  always_comb begin
    px0  = b_item_q.first_char ? b_item_q.start_x : pen_x_q;
    py0  = b_item_q.first_char ? b_item_q.start_y : pen_y_q;
    len0 = b_item_q.first_char ? 16'd0 : len_q;
    adv  = 9'd0;
    if (b_space_q) begin
      adv = {1'b0, space_adv_q};
    end else if (b_glyph_q) begin
      adv = {1'b0, glyph_rd_q.width} + 9'd1;
    end
    pen_x_d = sat_s16(18'(px0) + 18'(signed'({1'b0, adv})));
    len_sum = {1'b0, len0} + {8'd0, adv};
    len_d   = len_sum[16] ? 16'hffff : len_sum[15:0];
    xr      = sat_s16(18'(px0) + 18'(signed'({1'b0, glyph_rd_q.width})));
    yb      = sat_s16(18'(py0) - 18'(signed'({1'b0, font_height_q})));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
      len_q   <= '0;
    end else if (b_valid_q && b_go) begin
      pen_x_q <= pen_x_d;
      pen_y_q <= py0;
      len_q   <= len_d;
    end
  end

  // Only items that produce results enter the sequencer.
  assign b_to_c = b_valid_q && b_go && (b_glyph_q || b_item_q.last_char);

  // ---------------------------------------------------------------------
  // Result sequencer: one transfer per cycle while the output does not stall, from a registered quad.
  // ---------------------------------------------------------------------
  logic [2:0]         c_idx_q;
  logic               c_has_len_q;
  logic signed [15:0] c_xl_q, c_xr_q, c_yt_q, c_yb_q;
  logic [15:0]        c_left_q, c_right_q, c_len_q;
  logic               c_last;

  assign c_last = (c_idx_q == ResLength) || ((c_idx_q == VtxBotRightB) && !c_has_len_q);
  assign c_done = c_valid_q && !out_stall_i && c_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      c_idx_q   <= VtxTopLeftA;
    end else if (b_to_c) begin
      c_valid_q <= 1'b1;
      c_idx_q   <= b_glyph_q ? VtxTopLeftA : ResLength;
    end else if (c_valid_q && !out_stall_i) begin
      // advance through the corners; drop the item after its last result
      if (c_last) begin
        c_valid_q <= 1'b0;
      end else begin
        c_idx_q <= c_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_to_c) begin
      c_has_len_q <= b_item_q.last_char;
      c_xl_q      <= px0;
      c_xr_q      <= xr;
      c_yt_q      <= py0;
      c_yb_q      <= yb;
      c_left_q    <= glyph_rd_q.left;
      c_right_q   <= glyph_rd_q.right;
      c_len_q     <= len_d;
    end
  end

  assign out_valid_o = c_valid_q;

  always_comb begin
    out_data_o             = '0;
    out_data_o.result_kind = KindVertex;
    out_data_o.last        = c_last;
    case (c_idx_q)
      VtxTopLeftA, VtxTopLeftB: begin
        out_data_o.pos_x = c_xl_q;
        out_data_o.pos_y = c_yt_q;
        out_data_o.tex_u = c_left_q;
        out_data_o.tex_v = 1'b0;
      end
      VtxBotRightA, VtxBotRightB: begin
        out_data_o.pos_x = c_xr_q;
        out_data_o.pos_y = c_yb_q;
        out_data_o.tex_u = c_right_q;
        out_data_o.tex_v = 1'b1;
      end
      VtxBotLeft: begin
        out_data_o.pos_x = c_xl_q;
        out_data_o.pos_y = c_yb_q;
        out_data_o.tex_u = c_left_q;
        out_data_o.tex_v = 1'b1;
      end
      VtxTopRight: begin
        out_data_o.pos_x = c_xr_q;
        out_data_o.pos_y = c_yt_q;
        out_data_o.tex_u = c_right_q;
        out_data_o.tex_v = 1'b0;
      end
      ResLength: begin
        out_data_o.result_kind = KindLength;
        out_data_o.line_length = c_len_q;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/bfql_checker.sv -----
// Port-level checker for bitmap_font_quad_layout_top, bound to the top level.
// Depends on bfql_pkg for the payload structs and result kinds.
module bfql_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input bfql_pkg::out_t out_data_o
);
  import bfql_pkg::*;

  // Hold a stalled result unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Vertices of one glyph follow each other with no gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o)
    else $error("gap inside a glyph's result burst");

  // A length report always closes its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KindLength |-> out_data_o.last)
    else $error("length report not marked last");

  // The input side only backs up behind a waiting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with no pending result");

endmodule

bind bitmap_font_quad_layout_top bfql_checker u_bfql_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- test/tb.sv -----
// Testbench for bitmap_font_quad_layout_top: glyph loads, text lines, register settings.
// Predicts every vertex and line-length transfer on its own; needs bfql_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfql_pkg::*;

  localparam int GLYPH_COUNT = 95;
  localparam int CodeBase    = FirstCode;
  localparam int ClkHalf     = 2;
  localparam int ResetCycles = 10;
  localparam int IdleTail    = 8;        // idle time after the last owed result
  localparam int CycleLimit  = 400000;
  localparam int PhaseQuota  = 7;        // directed tests bring the total to about 310
  localparam int InW         = $bits(in_t);

  localparam logic TexTop    = 1'b0;
  localparam logic TexBottom = 1'b1;

  // Clock, reset and the three channels of the block.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CfgSpaceAdvance;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Predicted block state: glyph table, pen, running length and registers.
  glyph_t     font_glyphs [GLYPH_COUNT];
  bit         glyph_loaded [GLYPH_COUNT];
  int         pen_x     = 0;
  int         pen_y     = 0;
  int         line_len  = 0;
  logic [7:0] space_adv = SpaceAdvanceReset;
  logic [7:0] font_h    = FontHeightReset;

  // Vertices and length reports still owed by the block, oldest first.
  out_t expected_layout [$];

  int mismatch_count = 0;
  int result_count   = 0;
  int cycle_count    = 0;
  int rx_wait        = 0;
  bit tx_quiet       = 1'b0;
  bit rx_quiet       = 1'b0;

  bitmap_font_quad_layout_top #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #(ClkHalf) clk_i = 1'b1;
    #(ClkHalf) clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic bit is_glyph_code(input int code);
    return code > CodeBase && code - CodeBase < GLYPH_COUNT;
  endfunction

  function automatic out_t make_vertex(input int x, input int y, input logic [15:0] u,
                                       input logic v);
    out_t r;
    r = '0;
    r.result_kind = KindVertex;
    r.pos_x       = 16'(x);
    r.pos_y       = 16'(y);
    r.tex_u       = u;
    r.tex_v       = v;
    return r;
  endfunction

  // Move the pen right and grow the line length, both saturating.
  task automatic advance_pen(input int amount);
    pen_x    = clamp16(pen_x + amount);
    line_len = (line_len + amount > 65535) ? 65535 : line_len + amount;
  endtask

  // Work out the transfers one accepted item causes and queue them.
  task automatic predict_layout(input in_t item);
    out_t   batch [7];
    glyph_t g;
    int     code;
    int     n;
    int     xl;
    int     xr;
    int     yt;
    int     yb;
    code = item.char_code;
    n    = 0;
    if (item.command == CmdLoad) begin
      // Loads never answer; out-of-range slots are dropped.
      if (item.glyph_slot < GLYPH_COUNT) begin
        font_glyphs[item.glyph_slot] = '{left: item.tex_left, right: item.tex_right,
                                         width: item.glyph_width};
        glyph_loaded[item.glyph_slot] = 1'b1;
      end
      return;
    end
    if (item.first_char) begin
      pen_x    = int'($signed(item.start_x));
      pen_y    = int'($signed(item.start_y));
      line_len = 0;
    end
    if (code == CodeBase) begin
      advance_pen(int'(space_adv));
    end else if (is_glyph_code(code)) begin
      g  = font_glyphs[code - CodeBase];
      xl = pen_x;
      xr = clamp16(pen_x + int'(g.width));
      yt = pen_y;
      yb = clamp16(pen_y - int'(font_h));
      // Two triangles: TL, BR, BL then TL, TR, BR.
      batch[0] = make_vertex(xl, yt, g.left, TexTop);
      batch[1] = make_vertex(xr, yb, g.right, TexBottom);
      batch[2] = make_vertex(xl, yb, g.left, TexBottom);
      batch[3] = make_vertex(xl, yt, g.left, TexTop);
      batch[4] = make_vertex(xr, yt, g.right, TexTop);
      batch[5] = make_vertex(xr, yb, g.right, TexBottom);
      n = 6;
      advance_pen(int'(g.width) + 1);
    end
    if (item.last_char) begin
      batch[n]             = '0;
      batch[n].result_kind = KindLength;
      batch[n].line_length = 16'(line_len);
      n++;
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) batch[i].last = 1'b1;
      expected_layout.push_back(batch[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH %0d: %s", mismatch_count, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %h want %h", result_count, name, got,
                                want));
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_layout.size() == 0) begin
      report_mismatch($sformatf("result %0d not expected: %h", result_count, got));
      return;
    end
    want = expected_layout.pop_front();
    check_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
    check_field("pos_x", got.pos_x, want.pos_x);
    check_field("pos_y", got.pos_y, want.pos_y);
    check_field("tex_u", got.tex_u, want.tex_u);
    check_field("tex_v", 16'(got.tex_v), 16'(want.tex_v));
    check_field("line_length", got.line_length, want.line_length);
    check_field("last", 16'(got.last), 16'(want.last));
  endtask

  // Sample each result transfer and draw how long to stall before the next one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_result(out_data_o);
      result_count++;
      rx_wait <= rx_quiet ? 0 : $urandom_range(0, 14);
      // Flip now and then into a stretch that never stalls.
      if ($urandom_range(0, 39) == 0) rx_quiet <= !rx_quiet;
    end
  end

  // Drive the stall on the falling edge so the block samples a settled value.
  always @(negedge clk_i) begin
    if (rx_wait > 0) begin
      out_stall_i <= 1'b1;
      rx_wait     <= rx_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Give up on a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Fields a load does not look at get random values.
  function automatic in_t load_item(input logic [6:0] slot, input logic [15:0] left,
                                    input logic [15:0] right, input logic [7:0] width);
    in_t item;
    item             = InW'({$urandom, $urandom, $urandom});
    item.command     = CmdLoad;
    item.glyph_slot  = slot;
    item.tex_left    = left;
    item.tex_right   = right;
    item.glyph_width = width;
    return item;
  endfunction

  function automatic in_t char_item(input int code, input bit first, input bit last,
                                    input int sx, input int sy);
    in_t item;
    item            = InW'({$urandom, $urandom, $urandom});
    item.command    = CmdChar;
    item.char_code  = 8'(code);
    item.first_char = first;
    item.last_char  = last;
    item.start_x    = 16'(sx);
    item.start_y    = 16'(sy);
    return item;
  endfunction

  // Anything that changes state or causes a result counts toward a phase.
  function automatic bit has_effect(input in_t item);
    int code;
    code = item.char_code;
    if (item.command == CmdLoad) return item.glyph_slot < GLYPH_COUNT;
    return item.first_char || item.last_char || code == CodeBase || is_glyph_code(code);
  endfunction

  function automatic int random_pos();
    case ($urandom_range(0, 3))
      0: return int'($signed(16'($urandom)));
      1: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 300)
                                      : -32768 + $urandom_range(0, 300);
      default: return $urandom_range(0, 4000) - 2000;
    endcase
  endfunction

  function automatic logic [7:0] random_width();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Enter and leave at a falling edge. Keep valid high when no gap is drawn,
  // so back-to-back transfers never drop it.
  task automatic send_item(input in_t item);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    predict_layout(item);
  endtask

  // Drop valid and hold until every owed result has arrived and the pipe is empty.
  task automatic drain_layout();
    in_valid_i <= 1'b0;
    while (expected_layout.size() != 0) @(negedge clk_i);
    repeat (IdleTail) @(negedge clk_i);
  endtask

  // Write both registers back to back while the block is idle.
  task automatic set_layout_regs(input logic [7:0] space, input logic [7:0] height);
    drain_layout();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgSpaceAdvance;
    cfg_data_i  <= space;
    do @(posedge clk_i); while (!cfg_ready_o);
    space_adv = space;
    @(negedge clk_i);
    cfg_index_i <= CfgFontHeight;
    cfg_data_i  <= height;
    do @(posedge clk_i); while (!cfg_ready_o);
    font_h = height;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Load the glyph first if its entry was never written, then lay it out.
  task automatic send_random_char(input bit first, input bit last, inout int sent);
    in_t item;
    int  sel;
    int  code;
    sel = $urandom_range(0, 19);
    if (sel < 14) code = $urandom_range(CodeBase + 1, CodeBase + GLYPH_COUNT - 1);
    else if (sel < 17) code = CodeBase;
    else if (sel == 17) code = $urandom_range(0, CodeBase - 1);
    else code = $urandom_range(CodeBase + GLYPH_COUNT, 255);
    if (is_glyph_code(code) && !glyph_loaded[code - CodeBase]) begin
      send_item(load_item(7'(code - CodeBase), 16'($urandom), 16'($urandom),
                          random_width()));
      sent++;
    end
    // Break the line framing now and then.
    if ($urandom_range(0, 9) == 0) begin
      first = 1'($urandom_range(0, 1));
      last  = 1'($urandom_range(0, 1));
    end
    item = char_item(code, first, last, random_pos(), random_pos());
    if (has_effect(item)) sent++;
    send_item(item);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register reset values: space of 3, height of 16.
  task automatic test_reset_defaults();
    send_item(load_item(7'd33, 16'h1234, 16'hABCD, 8'd10));
    send_item(char_item(65, 1'b1, 1'b0, 100, 200));
    send_item(char_item(CodeBase, 1'b0, 1'b0, 0, 0));
    send_item(char_item(65, 1'b0, 1'b1, 0, 0));
    // A line that is one space: only the length report.
    send_item(char_item(CodeBase, 1'b1, 1'b1, -5, 7));
  endtask

  task automatic test_glyph_extremes();
    send_item(load_item(7'd1, 16'h0000, 16'h0000, 8'd0));
    send_item(load_item(7'd94, 16'hFFFF, 16'hFFFF, 8'd255));
    // Out-of-range slots are dropped.
    send_item(load_item(7'd95, 16'h5555, 16'hAAAA, 8'd77));
    send_item(load_item(7'd127, 16'hAAAA, 16'h5555, 8'd200));
    send_item(load_item(7'd0, 16'h0F0F, 16'hF0F0, 8'd9));
    send_item(char_item(33, 1'b1, 1'b0, 0, 0));
    send_item(char_item(126, 1'b0, 1'b1, 0, 0));
    send_item(char_item(126, 1'b1, 1'b1, -32768, 32767));
  endtask

  // Codes outside the table move nothing but still start and end lines.
  task automatic test_ignored_codes();
    send_item(char_item(0, 1'b1, 1'b0, 50, 60));
    send_item(char_item(31, 1'b0, 1'b0, 0, 0));
    send_item(char_item(127, 1'b0, 1'b0, 0, 0));
    send_item(char_item(255, 1'b0, 1'b1, 0, 0));
    send_item(char_item(128, 1'b1, 1'b1, -1, -1));
  endtask

  task automatic test_position_saturation();
    set_layout_regs(8'd255, 8'd255);
    // Right edge, bottom edge and pen all clip.
    send_item(char_item(126, 1'b1, 1'b0, 32700, -32700));
    send_item(char_item(126, 1'b0, 1'b0, 0, 0));
    send_item(char_item(CodeBase, 1'b0, 1'b1, 0, 0));
    send_item(char_item(33, 1'b1, 1'b1, 32767, -32768));
  endtask

  // 258 spaces of 255 pixels run the length past 65535.
  task automatic test_length_saturation();
    set_layout_regs(8'd255, 8'd1);
    for (int i = 0; i < 258; i++) send_item(char_item(CodeBase, i == 0, 1'b0, 0, 0));
    send_item(char_item(65, 1'b0, 1'b1, 0, 0));
  endtask

  task automatic random_phase(input int quota);
    in_t item;
    int  sent;
    int  len;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 4) == 0) begin
        // Burst of table loads, some aimed past the table.
        repeat ($urandom_range(1, 4)) begin
          item = load_item(($urandom_range(0, 7) == 0)
                             ? 7'($urandom_range(GLYPH_COUNT, 127))
                             : 7'($urandom_range(0, GLYPH_COUNT - 1)),
                           16'($urandom), 16'($urandom), random_width());
          if (has_effect(item)) sent++;
          send_item(item);
        end
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_random_char(i == 0, i == len - 1, sent);
      end
      if ($urandom_range(0, 4) == 0) tx_quiet = !tx_quiet;
      // Hold off now and then until the block has caught up.
      if ($urandom_range(0, 24) == 0) drain_layout();
    end
  endtask

  task automatic test_random_layout();
    set_layout_regs(8'd0, 8'd0);
    random_phase(PhaseQuota);
    set_layout_regs(8'd255, 8'd255);
    random_phase(PhaseQuota);
    repeat (2) begin
      set_layout_regs(8'($urandom), 8'($urandom));
      random_phase(PhaseQuota);
    end
  endtask

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_glyph_extremes();
    test_ignored_codes();
    test_position_saturation();
    test_length_saturation();
    test_random_layout();
    drain_layout();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
